[hdl/mah_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the magnetometer
// average and heading block. Depends on nothing; every other file imports it.
package mah_pkg;

   // Field widths of a request and a response.
   localparam int SAMPLE_W = 16;
   localparam int HEAD_W   = 9;

   // CORDIC vector width: sample scaled by 256, plus headroom for gain and sign.
   localparam int CX_W = 28;
   // Angle width in degrees, Q16, with room for base angle plus offset.
   localparam int ANG_W = 27;

   localparam int ATAN_LEN   = 24;
   localparam int ATAN_IDX_W = 5;

   localparam logic signed [ANG_W-1:0] DEG180_Q16 = ANG_W'(180 * 65536);
   localparam logic signed [ANG_W-1:0] DEG360_Q16 = ANG_W'(360 * 65536);

   // Headings returned directly for vectors that lie on an axis.
   localparam logic [HEAD_W-1:0] HEAD_90  = HEAD_W'(90);
   localparam logic [HEAD_W-1:0] HEAD_180 = HEAD_W'(180);
   localparam logic [HEAD_W-1:0] HEAD_270 = HEAD_W'(270);
   localparam logic [HEAD_W-1:0] HEAD_360 = HEAD_W'(360);

   // Axis tags that travel with a sum through the divider.
   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X    = 2'd0;
   localparam axis_type AXIS_Y    = 2'd1;
   localparam axis_type AXIS_Z    = 2'd2;
   localparam axis_type AXIS_NONE = 2'd3;

   // Control that accompanies one operand through the divider pipeline.
   typedef struct packed {
      logic     valid;
      axis_type axis;
   } div_tag_type;

   // atan(2^-i) in degrees, Q16, rounded to nearest.
   function automatic logic [ANG_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic [ANG_W-1:0] val;
      case (idx)
         5'd0:    val = ANG_W'(2949120);
         5'd1:    val = ANG_W'(1740967);
         5'd2:    val = ANG_W'(919879);
         5'd3:    val = ANG_W'(466945);
         5'd4:    val = ANG_W'(234379);
         5'd5:    val = ANG_W'(117304);
         5'd6:    val = ANG_W'(58666);
         5'd7:    val = ANG_W'(29335);
         5'd8:    val = ANG_W'(14668);
         5'd9:    val = ANG_W'(7334);
         5'd10:   val = ANG_W'(3667);
         5'd11:   val = ANG_W'(1833);
         5'd12:   val = ANG_W'(917);
         5'd13:   val = ANG_W'(458);
         5'd14:   val = ANG_W'(229);
         5'd15:   val = ANG_W'(115);
         5'd16:   val = ANG_W'(57);
         5'd17:   val = ANG_W'(29);
         5'd18:   val = ANG_W'(14);
         5'd19:   val = ANG_W'(7);
         5'd20:   val = ANG_W'(4);
         5'd21:   val = ANG_W'(2);
         5'd22:   val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[hdl/mah_ring.sv]
`timescale 1ns / 1ps
// Sample rings for the three axes with their running sums.
// Depends on mah_pkg.
module mah_ring
   import mah_pkg::*;
#(
   parameter int WINDOW = 10,
   parameter int SUM_W  = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic                       wr_en,
   input  logic signed [SAMPLE_W-1:0] wr_x,
   input  logic signed [SAMPLE_W-1:0] wr_y,
   input  logic signed [SAMPLE_W-1:0] wr_z,
   output logic signed [SUM_W-1:0]    x_sum,
   output logic signed [SUM_W-1:0]    y_sum,
   output logic signed [SUM_W-1:0]    z_sum
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   logic [3*SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [3*SAMPLE_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  wrapped_ff;
   logic signed [SUM_W-1:0] x_sum_ff, y_sum_ff, z_sum_ff;
   logic signed [SAMPLE_W-1:0] old_x, old_y, old_z;

   // Entries are written in slot order, so before the first wrap the slot
   // being replaced has never been written and counts as zero.
   assign old_x = wrapped_ff ? rd_data_ff[3*SAMPLE_W-1:2*SAMPLE_W] : '0;
   assign old_y = wrapped_ff ? rd_data_ff[2*SAMPLE_W-1:SAMPLE_W]   : '0;
   assign old_z = wrapped_ff ? rd_data_ff[SAMPLE_W-1:0]            : '0;

   // Ring storage: read the oldest entry on rd_en, then overwrite it on wr_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[slot_ff];
      end
      if (wr_en) begin
         ring_mem[slot_ff] <= {wr_x, wr_y, wr_z};
      end
   end

   // Slot pointer, wrap flag and running sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
         x_sum_ff   <= '0;
         y_sum_ff   <= '0;
         z_sum_ff   <= '0;
      end else if (wr_en) begin
         x_sum_ff <= x_sum_ff - SUM_W'(old_x) + SUM_W'(wr_x);
         y_sum_ff <= y_sum_ff - SUM_W'(old_y) + SUM_W'(wr_y);
         z_sum_ff <= z_sum_ff - SUM_W'(old_z) + SUM_W'(wr_z);
         if (slot_ff == LAST_SLOT) begin
            slot_ff    <= '0;
            wrapped_ff <= 1'b1;
         end else begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
      end
   end

   assign x_sum = x_sum_ff;
   assign y_sum = y_sum_ff;
   assign z_sum = z_sum_ff;

endmodule

[hdl/mah_div.sv]
`timescale 1ns / 1ps
// Two-stage divider by the window length, truncating toward zero, using a
// reciprocal multiply and one correction step. Depends on mah_pkg.
module mah_div
   import mah_pkg::*;
#(
   parameter int WINDOW = 10,
   parameter int SUM_W  = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  div_tag_type                in_tag,
   input  logic signed [SUM_W-1:0]    in_sum,
   output div_tag_type                out_tag,
   output logic signed [SAMPLE_W-1:0] out_avg
);

   // Shift chosen so the reciprocal estimate is short by at most one.
   localparam int K      = SUM_W + 1;
   localparam int PROD_W = 2 * SUM_W + 2;
   localparam logic [K:0]       RECIP = (K + 1)'((64'd1 << K) / 64'(WINDOW));
   localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);

   div_tag_type        tag1_ff, tag2_ff;
   logic               neg1_ff;
   logic [SUM_W-1:0]   mag1_ff;
   logic [PROD_W-1:0]  prod1_ff;
   logic [SUM_W-1:0]   mag_in;
   logic [SUM_W-1:0]   quot_est, rem, quot;
   logic [SUM_W-1:0]   signed_quot;
   logic signed [SAMPLE_W-1:0] avg_ff;

   assign mag_in = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);

   // Stage one: magnitude times reciprocal.
   always_ff @(posedge clock) begin
      neg1_ff  <= in_sum[SUM_W-1];
      mag1_ff  <= mag_in;
      prod1_ff <= PROD_W'(mag_in) * PROD_W'(RECIP);
   end

   // Stage two: correct the estimate and restore the sign.
   assign quot_est    = prod1_ff[K +: SUM_W];
   assign rem         = mag1_ff - SUM_W'(quot_est * WIN_C);
   assign quot        = (rem >= WIN_C) ? quot_est + SUM_W'(1) : quot_est;
   assign signed_quot = neg1_ff ? SUM_W'(-quot) : quot;

   always_ff @(posedge clock) begin
      avg_ff <= signed_quot[SAMPLE_W-1:0];
   end

   // Tags follow the operand down the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '{valid: 1'b0, axis: AXIS_NONE};
         tag2_ff <= '{valid: 1'b0, axis: AXIS_NONE};
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   assign out_tag = tag2_ff;
   assign out_avg = avg_ff;

endmodule

[hdl/mah_cordic.sv]
`timescale 1ns / 1ps
// Iterative vectoring CORDIC that turns the X and Y averages into a heading
// in whole degrees, one rotation per cycle. Depends on mah_pkg.
module mah_cordic
   import mah_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SAMPLE_W-1:0] ax,
   input  logic signed [SAMPLE_W-1:0] ay,
   output logic                       done,
   output logic [HEAD_W-1:0]          heading
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_RUN  = 2'd1;
   localparam logic [1:0] C_FIN  = 2'd2;

   logic [1:0]              cst_ff;
   logic [STEP_W-1:0]       step_ff;
   logic                    done_ff;
   logic [HEAD_W-1:0]       heading_ff;
   logic signed [CX_W-1:0]  x_ff, y_ff;
   logic signed [ANG_W-1:0] z_ff;

   logic                    special;
   logic [HEAD_W-1:0]       spec_head;
   logic signed [CX_W-1:0]  x_sc, y_sc, x_init, y_init;
   logic signed [ANG_W-1:0] z_init;
   logic signed [CX_W-1:0]  xs, ys, x_nxt, y_nxt;
   logic signed [ANG_W-1:0] atan_val, z_nxt, t_sum;
   logic [HEAD_W-1:0]       head_fin;

   // Vectors on an axis, or the null vector, bypass the iterations.
   always_comb begin
      special   = (ax == '0) || (ay == '0);
      spec_head = HEAD_180;
      if (ax == '0 && ay == '0) begin
         spec_head = HEAD_180;
      end else if (ay == '0) begin
         spec_head = ax[SAMPLE_W-1] ? HEAD_360 : HEAD_180;
      end else if (ax == '0) begin
         spec_head = ay[SAMPLE_W-1] ? HEAD_90 : HEAD_270;
      end
   end

   // Scale by 256 and fold the left half plane onto the right one.
   assign x_sc   = {{(CX_W - SAMPLE_W - 8){ax[SAMPLE_W-1]}}, ax, 8'h00};
   assign y_sc   = {{(CX_W - SAMPLE_W - 8){ay[SAMPLE_W-1]}}, ay, 8'h00};
   assign x_init = ax[SAMPLE_W-1] ? -x_sc : x_sc;
   assign y_init = ax[SAMPLE_W-1] ? -y_sc : y_sc;
   assign z_init = ax[SAMPLE_W-1] ? (ay[SAMPLE_W-1] ? -DEG180_Q16 : DEG180_Q16) : '0;

   // One shift-add rotation; direction follows the sign of y.
   assign xs       = x_ff >>> step_ff;
   assign ys       = y_ff >>> step_ff;
   assign atan_val = atan_q16(ATAN_IDX_W'(step_ff));
   always_comb begin
      if (y_ff > 0) begin
         x_nxt = x_ff + ys;
         y_nxt = y_ff - xs;
         z_nxt = z_ff + atan_val;
      end else begin
         x_nxt = x_ff - ys;
         y_nxt = y_ff + xs;
         z_nxt = z_ff - atan_val;
      end
   end

   // Offset by 180 degrees, clamp to the full circle and drop the fraction.
   assign t_sum = z_ff + DEG180_Q16;
   always_comb begin
      if (t_sum < 0) begin
         head_fin = '0;
      end else if (t_sum > DEG360_Q16) begin
         head_fin = HEAD_360;
      end else begin
         head_fin = t_sum[16 +: HEAD_W];
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         cst_ff  <= C_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (cst_ff)
            C_IDLE: begin
               if (start) begin
                  step_ff <= '0;
                  if (special) begin
                     done_ff <= 1'b1;
                  end else begin
                     cst_ff <= C_RUN;
                  end
               end
            end
            C_RUN: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == LAST_STEP) begin
                  cst_ff <= C_FIN;
               end
            end
            C_FIN: begin
               cst_ff  <= C_IDLE;
               done_ff <= 1'b1;
            end
            default: cst_ff <= C_IDLE;
         endcase
      end
   end

   // Vector, angle and result registers.
   always_ff @(posedge clock) begin
      if (cst_ff == C_IDLE && start) begin
         x_ff <= x_init;
         y_ff <= y_init;
         z_ff <= z_init;
         if (special) begin
            heading_ff <= spec_head;
         end
      end else if (cst_ff == C_RUN) begin
         x_ff <= x_nxt;
         y_ff <= y_nxt;
         z_ff <= z_nxt;
      end else if (cst_ff == C_FIN) begin
         heading_ff <= head_fin;
      end
   end

   assign done    = done_ff;
   assign heading = heading_ff;

endmodule

[hdl/magnetometer_average_heading_core.sv]
`timescale 1ns / 1ps
// Magnetometer window average and compass heading, top level.
// A request passes through the ring update, the divider (X, Y, then Z) and the CORDIC
// rotations before its response is valid; a null vector or one on an axis skips the
// rotations. A new request is taken only once the previous response is in the output
// register, where it waits. Synchronous active-high reset empties the rings and sums.
// Depends on mah_pkg, mah_ring, mah_div and mah_cordic.
module magnetometer_average_heading_core
   import mah_pkg::*;
#(
   parameter int WINDOW       = 10,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_x_sample,
   input  logic signed [SAMPLE_W-1:0] req_y_sample,
   input  logic signed [SAMPLE_W-1:0] req_z_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_avg_x,
   output logic signed [SAMPLE_W-1:0] rsp_avg_y,
   output logic signed [SAMPLE_W-1:0] rsp_avg_z,
   output logic [HEAD_W-1:0]          rsp_heading_deg
);

   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_HEAD = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       req_fire;
   logic       rsp_load;

   logic signed [SAMPLE_W-1:0] smp_x_ff, smp_y_ff, smp_z_ff;
   logic signed [SUM_W-1:0]    x_sum, y_sum, z_sum;
   axis_type                   feed_ff;
   div_tag_type                div_in, div_out;
   logic signed [SUM_W-1:0]    div_sum;
   logic signed [SAMPLE_W-1:0] div_avg;
   logic signed [SAMPLE_W-1:0] avg_x_ff, avg_y_ff, avg_z_ff;
   logic                       cordic_start, cordic_done;
   logic [HEAD_W-1:0]          cordic_heading;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [HEAD_W-1:0]          rsp_head_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Hold the accepted request while the ring is updated.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         smp_x_ff <= req_x_sample;
         smp_y_ff <= req_y_sample;
         smp_z_ff <= req_z_sample;
      end
   end

   mah_ring #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .rd_en (req_fire),
      .wr_en (state_ff == S_SUM),
      .wr_x  (smp_x_ff),
      .wr_y  (smp_y_ff),
      .wr_z  (smp_z_ff),
      .x_sum (x_sum),
      .y_sum (y_sum),
      .z_sum (z_sum)
   );

   // Feed the three sums into the divider one per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_ff <= AXIS_NONE;
      end else if (state_ff == S_SUM) begin
         feed_ff <= AXIS_X;
      end else if (state_ff == S_DIV && feed_ff != AXIS_NONE) begin
         feed_ff <= feed_ff + 2'd1;
      end
   end

   always_comb begin
      case (feed_ff)
         AXIS_X:  div_sum = x_sum;
         AXIS_Y:  div_sum = y_sum;
         default: div_sum = z_sum;
      endcase
   end

   assign div_in.valid = (state_ff == S_DIV) && (feed_ff != AXIS_NONE);
   assign div_in.axis  = feed_ff;

   mah_div #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (div_in),
      .in_sum  (div_sum),
      .out_tag (div_out),
      .out_avg (div_avg)
   );

   // Collect the averages by axis tag.
   always_ff @(posedge clock) begin
      if (div_out.valid) begin
         case (div_out.axis)
            AXIS_X:  avg_x_ff <= div_avg;
            AXIS_Y:  avg_y_ff <= div_avg;
            AXIS_Z:  avg_z_ff <= div_avg;
            default: ;
         endcase
      end
   end

   // The Z average arrives last, so X and Y are ready for the heading.
   assign cordic_start = div_out.valid && (div_out.axis == AXIS_Z);

   mah_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .ax      (avg_x_ff),
      .ay      (avg_y_ff),
      .done    (cordic_done),
      .heading (cordic_heading)
   );

   // Request sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_SUM;
         S_SUM:   state_in = S_DIV;
         S_DIV:   if (cordic_start) state_in = S_HEAD;
         S_HEAD:  if (cordic_done) state_in = S_OUT;
         S_OUT:   if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Response register; it holds until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff    <= avg_x_ff;
         rsp_y_ff    <= avg_y_ff;
         rsp_z_ff    <= avg_z_ff;
         rsp_head_ff <= cordic_heading;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_avg_x       = rsp_x_ff;
   assign rsp_avg_y       = rsp_y_ff;
   assign rsp_avg_z       = rsp_z_ff;
   assign rsp_heading_deg = rsp_head_ff;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for magnetometer_average_heading_core: window averages and heading.
// Depends on mah_pkg and the core; a directed table runs first, then random samples.
module testbench;
   import mah_pkg::*;

   localparam int WINDOW       = 10;
   localparam int CORDIC_STEPS = 16;
   localparam int RANDOM_ITEMS = 250;
   localparam int DRAIN_CYCLES = 60;

   localparam longint HALF_TURN_Q16 = 180 * 65536;
   localparam longint FULL_TURN_Q16 = 360 * 65536;

   // Arctangent of 2^-i in degrees, Q16, rounded to nearest.
   localparam longint ATAN_DEG_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   // Idle and stall percentages for each traffic phase.
   localparam int SENDER_IDLE [4]    = '{0, 61, 0, 31};
   localparam int RECEIVER_STALL [4] = '{0, 0, 61, 31};

   // Sample values that sit on the edges of the range.
   localparam logic [SAMPLE_W-1:0] EDGE_VALUES [8] = '{
      16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF, 16'hFFF6, 16'h000A};

   typedef enum int {FLAVOR_FULL, FLAVOR_SMALL, FLAVOR_EDGE} axis_flavor_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_x;
      logic [SAMPLE_W-1:0] avg_y;
      logic [SAMPLE_W-1:0] avg_z;
      logic [HEAD_W-1:0]   heading;
   } heading_result_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
      logic [SAMPLE_W-1:0] z;
      logic                typed;
      heading_result_type  want;
   } sample_row_type;

   // Directed requests. Rows with typed set carry a hand-worked result; the rest
   // are predicted. The opening rows walk the axis cases and the averaging truncation.
   localparam sample_row_type DIRECTED_ROWS [20] = '{
      '{0, 0, 0, 1, '{0, 0, 0, 180}},
      '{32767, 0, 32767, 1, '{3276, 0, 3276, 180}},
      '{-32768, 0, -32768, 1, '{0, 0, 0, 180}},
      '{-32768, 0, -32768, 1, '{-3276, 0, -3276, 360}},
      '{32767, 32767, 0, 1, '{0, 3276, -3276, 270}},
      '{0, -32768, 32767, 1, '{0, 0, 0, 180}},
      '{0, -32768, 0, 1, '{0, -3276, 0, 90}},
      '{32767, 32767, 32767, 1, '{3276, 0, 3276, 180}},
      '{-32768, -32768, -32768, 1, '{0, -3277, 0, 90}},
      '{20000, 30000, 1, 0, '0},
      '{-20000, 30000, -1, 0, '0},
      '{-20000, -30000, 21845, 0, '0},
      '{20000, -30000, -21846, 0, '0},
      '{32767, -32768, 12345, 0, '0},
      '{-32768, 32767, 0, 0, '0},
      '{-32768, -1, 0, 0, '0},
      '{-32768, 1, 0, 0, '0},
      '{1, -32768, 0, 0, '0},
      '{-1, 32767, 0, 0, '0},
      '{32767, -1, 0, 0, '0}};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_x_sample = '0;
   logic [SAMPLE_W-1:0] req_y_sample = '0;
   logic [SAMPLE_W-1:0] req_z_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_avg_x;
   logic [SAMPLE_W-1:0] rsp_avg_y;
   logic [SAMPLE_W-1:0] rsp_avg_z;
   logic [HEAD_W-1:0]   rsp_heading_deg;

   // Predictor state: three sample windows with their running sums.
   logic signed [SAMPLE_W-1:0] hist_x [WINDOW];
   logic signed [SAMPLE_W-1:0] hist_y [WINDOW];
   logic signed [SAMPLE_W-1:0] hist_z [WINDOW];
   int                         total_x = 0;
   int                         total_y = 0;
   int                         total_z = 0;
   int                         next_slot = 0;

   heading_result_type awaited_results [$];
   int                 mismatches = 0;
   int                 idle_pct = 0;
   int                 stall_pct = 0;

   magnetometer_average_heading_core #(
      .WINDOW      (WINDOW),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_x_sample   (req_x_sample),
      .req_y_sample   (req_y_sample),
      .req_z_sample   (req_z_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_avg_x      (rsp_avg_x),
      .rsp_avg_y      (rsp_avg_y),
      .rsp_avg_z      (rsp_avg_z),
      .rsp_heading_deg(rsp_heading_deg)
   );

   // Free-running 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Compass heading of an averaged vector by vectoring CORDIC, worked in Q16 degrees and returned in whole degrees.
   function automatic logic [HEAD_W-1:0] cordic_heading(input int ax, input int ay);
      longint vx, vy, nx, angle, base, total;
      int     step;
      if (ax == 0 && ay == 0) return HEAD_W'(180);
      if (ay == 0) return (ax > 0) ? HEAD_W'(180) : HEAD_W'(360);
      if (ax == 0) return (ay > 0) ? HEAD_W'(270) : HEAD_W'(90);
      vx = longint'(ax) * 256;
      vy = longint'(ay) * 256;
      base = 0;
      // Fold the left half-plane onto the right one and remember the half turn.
      if (ax < 0) begin
         vx = -vx;
         vy = -vy;
         base = (ay >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      end
      angle = 0;
      for (step = 0; step < CORDIC_STEPS && step < 24; step++) begin
         if (vy > 0) begin
            nx = vx + (vy >>> step);
            vy = vy - (vx >>> step);
            angle = angle + ATAN_DEG_Q16[step];
         end else begin
            nx = vx - (vy >>> step);
            vy = vy + (vx >>> step);
            angle = angle - ATAN_DEG_Q16[step];
         end
         vx = nx;
      end
      total = base + angle + HALF_TURN_Q16;
      if (total < 0) total = 0;
      if (total > FULL_TURN_Q16) total = FULL_TURN_Q16;
      return HEAD_W'(total >>> 16);
   endfunction

   // Push one sample into the windows and work out the averages and heading.
   function automatic heading_result_type advance_window(
      input logic signed [SAMPLE_W-1:0] xs,
      input logic signed [SAMPLE_W-1:0] ys,
      input logic signed [SAMPLE_W-1:0] zs);
      heading_result_type res;
      int                 ax, ay, az;
      total_x = total_x - hist_x[next_slot] + xs;
      total_y = total_y - hist_y[next_slot] + ys;
      total_z = total_z - hist_z[next_slot] + zs;
      hist_x[next_slot] = xs;
      hist_y[next_slot] = ys;
      hist_z[next_slot] = zs;
      next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
      ax = total_x / WINDOW;
      ay = total_y / WINDOW;
      az = total_z / WINDOW;
      res.avg_x = SAMPLE_W'(ax);
      res.avg_y = SAMPLE_W'(ay);
      res.avg_z = SAMPLE_W'(az);
      res.heading = cordic_heading(ax, ay);
      return res;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_axis(input axis_flavor_type flavor);
      case (flavor)
         FLAVOR_SMALL: return SAMPLE_W'(int'($urandom_range(40)) - 20);
         FLAVOR_EDGE:  return EDGE_VALUES[$urandom_range(7)];
         default:      return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Offer one request, idling first at the current rate, and record its result on acceptance.
   task automatic send_sample(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                              input logic [SAMPLE_W-1:0] zs, input logic typed,
                              input heading_result_type want);
      heading_result_type predicted;
      while (int'($urandom_range(99)) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_x_sample <= xs;
      req_y_sample <= ys;
      req_z_sample <= zs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_window(xs, ys, zs);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   task automatic compare_field(input string label, input logic signed [SAMPLE_W:0] want,
                                input logic signed [SAMPLE_W:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // Response side: random back-pressure and in-order checking.
   always @(posedge clock) begin
      heading_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected, actual %0d %0d %0d %0d", $time,
                        $signed(rsp_avg_x), $signed(rsp_avg_y), $signed(rsp_avg_z),
                        rsp_heading_deg);
            end else begin
               want = awaited_results.pop_front();
               compare_field("avg_x", $signed(want.avg_x), $signed(rsp_avg_x));
               compare_field("avg_y", $signed(want.avg_y), $signed(rsp_avg_y));
               compare_field("avg_z", $signed(want.avg_z), $signed(rsp_avg_z));
               compare_field("heading_deg", want.heading, rsp_heading_deg);
            end
         end
         rsp_ready <= (int'($urandom_range(99)) >= stall_pct);
      end
   end

   // Stimulus: reset, directed table, then random phases with varying idle and stall rates.
   initial begin
      int           phase, sent, run_len, row;
      logic [SAMPLE_W-1:0] sx, sy, sz;
      for (row = 0; row < WINDOW; row++) begin
         hist_x[row] = '0;
         hist_y[row] = '0;
         hist_z[row] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < 20; row++) begin
         send_sample(DIRECTED_ROWS[row].x, DIRECTED_ROWS[row].y, DIRECTED_ROWS[row].z,
                     DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);
      end

      for (phase = 0; phase < 4; phase++) begin
         idle_pct  = SENDER_IDLE[phase];
         stall_pct = RECEIVER_STALL[phase];
         sent = 0;
         while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0) begin
               // Hold one sample long enough to fill the window, so the averages
               // land exactly on chosen values, axes and range edges among them.
               sx = pick_axis(axis_flavor_type'($urandom_range(2)));
               sy = pick_axis(axis_flavor_type'($urandom_range(2)));
               sz = pick_axis(axis_flavor_type'($urandom_range(2)));
               run_len = $urandom_range(WINDOW, WINDOW + 4);
               repeat (run_len) send_sample(sx, sy, sz, 1'b0, '0);
               sent += run_len;
            end else begin
               send_sample(pick_axis(FLAVOR_FULL), pick_axis(FLAVOR_FULL),
                           pick_axis(FLAVOR_FULL), 1'b0, '0);
               sent++;
            end
         end
         // Hold off new requests until every outstanding response has come back.
         req_valid <= 1'b0;
         while (awaited_results.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("magnetometer_average_heading_core regression: pass");
      end else begin
         $display("magnetometer_average_heading_core regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("magnetometer_average_heading_core regression: fail");
      $finish;
   end

endmodule
